>>> design/date_add_days_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for date_add_days_core
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_CORE_MACROS_SVH
`define DATE_ADD_DAYS_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DAD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("date_add_days_core: same-cycle check failed");

// next-cycle implication, disabled during reset
`define DAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("date_add_days_core: next-cycle check failed");

`endif

>>> design/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Types, constants and month-length lookup for the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFF_W    = 16;
   localparam int STATUS_W = 3;
   // running day count: start day plus largest offset
   localparam int ACC_W    = 17;

   localparam int MAX_OFFSET = 65535;
   localparam int YEAR_MIN   = 1583;
   localparam int YEAR_TOP   = 16383;
   localparam int LEAP_CYCLE = 400;
   localparam int CENTURY    = 100;
   localparam int MONTHS     = 12;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_YEAR  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_YEAR_OVF  = 3'd4;

   typedef struct packed {
      logic             borrow;
      logic [ACC_W-1:0] diff;
   } sub_result_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> design/date_add_days_core.sv
// Flow: S_MOD reduces the year modulo 400 through the single shared subtractor;
// S_CHECK ends with an error result for an invalid start date, else S_STEP walks
// one month boundary at a time in the same unit until the remaining day count
// fits the current month or the top year saturates.
// One transaction at a time: busy stays high until the result strobe.
// Synchronous active-high reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
// date_add_days_core
// Adds a day offset to a Gregorian date, one month per cycle, with checking.
// ----------------------------------------------------------------------------
module date_add_days_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dad_pkg::YEAR_W-1:0]     req_start_year,
   input  logic [dad_pkg::MONTH_W-1:0]    req_start_month,
   input  logic [dad_pkg::DAY_W-1:0]      req_start_day,
   input  logic [dad_pkg::OFF_W-1:0]      req_days_away,
   output logic                           rsp_valid,
   output logic [dad_pkg::YEAR_W-1:0]     rsp_result_year,
   output logic [dad_pkg::MONTH_W-1:0]    rsp_result_month,
   output logic [dad_pkg::DAY_W-1:0]      rsp_result_day,
   output logic [dad_pkg::STATUS_W-1:0]   rsp_status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOD   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;

   localparam logic [2:0] K_TOP = 3'd5;   // 400 << 5 fits in 14 bits; 400 << 6 exceeds every 14-bit year

   logic [2:0]                     state_ff, state_in;
   logic [2:0]                     k_ff, k_in;
   logic [dad_pkg::YEAR_W-1:0]     ymod_ff, ymod_in;
   logic [dad_pkg::YEAR_W-1:0]     year_ff, year_in;
   logic [dad_pkg::MONTH_W-1:0]    month_ff, month_in;
   logic [dad_pkg::DAY_W-1:0]      day_ff, day_in;
   logic [dad_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dad_pkg::YEAR_W-1:0]     rsp_year_ff, rsp_year_in;
   logic [dad_pkg::MONTH_W-1:0]    rsp_month_ff, rsp_month_in;
   logic [dad_pkg::DAY_W-1:0]      rsp_day_ff, rsp_day_in;
   logic [dad_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [dad_pkg::OFF_W-1:0]      off_sat;
   logic                           leap;
   logic [dad_pkg::DAY_W-1:0]      mlen;
   logic [dad_pkg::ACC_W-1:0]      sub_a, sub_b;
   dad_pkg::sub_result_type        sub_res;
   logic [dad_pkg::STATUS_W-1:0]   chk_status;
   logic [dad_pkg::YEAR_W-1:0]     ymod_inc;

   assign off_sat = (32'(req_days_away) > dad_pkg::MAX_OFFSET) ?
                    16'(dad_pkg::MAX_OFFSET) : req_days_away;

   // ymod_ff holds year mod 400 after the reduction phase
   assign leap = (ymod_ff[1:0] == 2'd0) &&
                 (ymod_ff != 14'(dad_pkg::CENTURY)) &&
                 (ymod_ff != 14'(2 * dad_pkg::CENTURY)) &&
                 (ymod_ff != 14'(3 * dad_pkg::CENTURY));

   assign mlen = dad_pkg::month_days(month_ff, leap);

   assign ymod_inc = (ymod_ff == 14'(dad_pkg::LEAP_CYCLE - 1)) ? '0 : ymod_ff + 14'd1;

   always_comb begin
      if (state_ff == S_MOD) begin
         sub_a = {3'b000, ymod_ff};
         sub_b = 17'(dad_pkg::LEAP_CYCLE) << k_ff;
      end else begin
         sub_a = acc_ff;
         sub_b = 17'(mlen);
      end
   end

   dad_sub_unit u_sub (
      .a   (sub_a),
      .b   (sub_b),
      .res (sub_res)
   );

   always_comb begin
      priority if (month_ff == 4'd0 || month_ff > 4'(dad_pkg::MONTHS)) begin
         chk_status = dad_pkg::ST_BAD_MONTH;
      end else if (day_ff == 5'd0 || day_ff > mlen) begin
         chk_status = dad_pkg::ST_BAD_DAY;
      end else if (year_ff < 14'(dad_pkg::YEAR_MIN)) begin
         chk_status = dad_pkg::ST_BAD_YEAR;
      end else begin
         chk_status = dad_pkg::ST_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      ymod_in       = ymod_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = 1'b0;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               year_in  = req_start_year;
               month_in = req_start_month;
               day_in   = req_start_day;
               ymod_in  = req_start_year;
               acc_in   = 17'(req_start_day) + 17'(off_sat);
               k_in     = K_TOP;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (!sub_res.borrow) begin
               ymod_in = sub_res.diff[dad_pkg::YEAR_W-1:0];
            end
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (chk_status != dad_pkg::ST_OK) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = '0;
               rsp_month_in  = '0;
               rsp_day_in    = '0;
               rsp_status_in = chk_status;
               state_in      = S_IDLE;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            // acc <= month length ends the walk
            if (sub_res.borrow || sub_res.diff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = year_ff;
               rsp_month_in  = month_ff;
               rsp_day_in    = acc_ff[dad_pkg::DAY_W-1:0];
               rsp_status_in = dad_pkg::ST_OK;
               state_in      = S_IDLE;
            end else begin
               acc_in = sub_res.diff;
               if (month_ff == 4'(dad_pkg::MONTHS)) begin
                  if (year_ff >= 14'(dad_pkg::YEAR_TOP)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_year_in   = year_ff;
                     rsp_month_in  = month_ff;
                     rsp_day_in    = 5'd31;
                     rsp_status_in = dad_pkg::ST_YEAR_OVF;
                     state_in      = S_IDLE;
                  end else begin
                     year_in  = year_ff + 14'd1;
                     ymod_in  = ymod_inc;
                     month_in = 4'd1;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      ymod_ff       <= ymod_in;
      year_ff       <= year_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      acc_ff        <= acc_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_year  = rsp_year_ff;
   assign rsp_result_month = rsp_month_ff;
   assign rsp_result_day   = rsp_day_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> design/dad_sub_unit.sv
// ----------------------------------------------------------------------------
// dad_sub_unit
// Shared subtract/compare unit: used for year reduction and month stepping.
// ----------------------------------------------------------------------------
module dad_sub_unit (
   input  logic [dad_pkg::ACC_W-1:0] a,
   input  logic [dad_pkg::ACC_W-1:0] b,
   output dad_pkg::sub_result_type   res
);

   logic [dad_pkg::ACC_W:0] wide;

   assign wide       = {1'b0, a} - {1'b0, b};
   assign res.borrow = wide[dad_pkg::ACC_W];
   assign res.diff   = wide[dad_pkg::ACC_W-1:0];

endmodule

>>> design/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks for date_add_days_core, bound to the top level.
// ----------------------------------------------------------------------------
`include "date_add_days_core_macros.svh"

module dad_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [dad_pkg::YEAR_W-1:0]     rsp_result_year,
   input logic [dad_pkg::MONTH_W-1:0]    rsp_result_month,
   input logic [dad_pkg::DAY_W-1:0]      rsp_result_day,
   input logic [dad_pkg::STATUS_W-1:0]   rsp_status
);

   logic rsp_err;
   logic rsp_date_ok;
   logic rsp_zero;

   assign rsp_err = (rsp_status == dad_pkg::ST_BAD_MONTH) ||
                    (rsp_status == dad_pkg::ST_BAD_DAY) ||
                    (rsp_status == dad_pkg::ST_BAD_YEAR);

   assign rsp_date_ok = (rsp_result_month != 4'd0) &&
                        (rsp_result_month <= 4'(dad_pkg::MONTHS)) &&
                        (rsp_result_day != 5'd0);

   assign rsp_zero = (rsp_result_year == '0) &&
                     (rsp_result_month == '0) &&
                     (rsp_result_day == '0);

   // a new transaction keeps the block busy through its work
   `DAD_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // a result only closes a transaction
   `DAD_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // strobe is a single cycle
   `DAD_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   // rejected start date returns an all-zero date
   `DAD_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_err, rsp_zero)
   // successful result is a real calendar position
   `DAD_ASSERT_NOW(a_ok_date, clock, reset, rsp_valid && rsp_status == dad_pkg::ST_OK, rsp_date_ok)

endmodule

bind date_add_days_core dad_checker u_dad_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_result_year  (rsp_result_year),
   .rsp_result_month (rsp_result_month),
   .rsp_result_day   (rsp_result_day),
   .rsp_status       (rsp_status)
);

>>> test/date_add_days_core_tb.sv
// ----------------------------------------------------------------------------
// date_add_days_core_tb
// Drives start dates and day offsets into the date adder and checks every
// result against a behavioral date-stepping predictor kept in a scoreboard.
// A directed pass covers the field extremes, each status code, leap and
// century rules and year saturation. It is followed by random dates: mostly
// well-formed, with random offsets that are usually short, plus raw noise.
// ----------------------------------------------------------------------------
module date_add_days_core_tb;

   localparam int WATCHDOG_LIMIT = 12000;
   localparam int RANDOM_ITEMS   = 270;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      logic [dad_pkg::YEAR_W-1:0]   year;
      logic [dad_pkg::MONTH_W-1:0]  month;
      logic [dad_pkg::DAY_W-1:0]    day;
      logic [dad_pkg::STATUS_W-1:0] status;
   } date_rsp_type;

   class date_scoreboard;
      date_rsp_type expected_dates[$];
      int unsigned  errors;

      function new();
         errors = 0;
      endfunction

      static function bit leap_year(input int unsigned y);
         return ((y % 4 == 0) && (y % dad_pkg::CENTURY != 0)) ||
                (y % dad_pkg::LEAP_CYCLE == 0);
      endfunction

      static function int unsigned month_length(input int unsigned m, input int unsigned y);
         int unsigned lens[12];
         int unsigned len;
         lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         len  = lens[(m - 1) % dad_pkg::MONTHS];
         if (m == 2 && leap_year(y))
            len++;
         return len;
      endfunction

      // validate, then walk forward one month at a time
      function date_rsp_type add_days_to_date(input logic [dad_pkg::YEAR_W-1:0] yr,
                                              input logic [dad_pkg::MONTH_W-1:0] mo,
                                              input logic [dad_pkg::DAY_W-1:0] dy,
                                              input logic [dad_pkg::OFF_W-1:0] off);
         date_rsp_type r;
         int unsigned  y, m, d;
         r = '0;
         if (mo < 1 || mo > dad_pkg::MONTHS) begin
            r.status = dad_pkg::ST_BAD_MONTH;
         end else if (dy < 1 || 32'(dy) > month_length(32'(mo), 32'(yr))) begin
            r.status = dad_pkg::ST_BAD_DAY;
         end else if (yr < dad_pkg::YEAR_MIN) begin
            r.status = dad_pkg::ST_BAD_YEAR;
         end else begin
            y = 32'(yr);
            m = 32'(mo);
            d = 32'(dy) + 32'(off);
            r.status = dad_pkg::ST_OK;
            while (r.status == dad_pkg::ST_OK && d > month_length(m, y)) begin
               d -= month_length(m, y);
               if (m == dad_pkg::MONTHS) begin
                  if (y >= dad_pkg::YEAR_TOP) begin
                     // saturate at the last representable day
                     r.status = dad_pkg::ST_YEAR_OVF;
                     d = 31;
                  end else begin
                     y++;
                     m = 1;
                  end
               end else begin
                  m++;
               end
            end
            r.year  = y[dad_pkg::YEAR_W-1:0];
            r.month = m[dad_pkg::MONTH_W-1:0];
            r.day   = d[dad_pkg::DAY_W-1:0];
         end
         return r;
      endfunction

      function void note_input(input logic [dad_pkg::YEAR_W-1:0] yr,
                               input logic [dad_pkg::MONTH_W-1:0] mo,
                               input logic [dad_pkg::DAY_W-1:0] dy,
                               input logic [dad_pkg::OFF_W-1:0] off);
         expected_dates.push_back(add_days_to_date(yr, mo, dy, off));
      endfunction

      task report_mismatch(input string what, input int unsigned got, input int unsigned want);
         $display("MISMATCH %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_result(input date_rsp_type got);
         date_rsp_type want;
         if (expected_dates.size() == 0) begin
            report_mismatch("unexpected result, pending count", 1, 0);
         end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year)
               report_mismatch("result_year", 32'(got.year), 32'(want.year));
            if (got.month !== want.month)
               report_mismatch("result_month", 32'(got.month), 32'(want.month));
            if (got.day !== want.day)
               report_mismatch("result_day", 32'(got.day), 32'(want.day));
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
         end
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [dad_pkg::YEAR_W-1:0]   req_start_year;
   logic [dad_pkg::MONTH_W-1:0]  req_start_month;
   logic [dad_pkg::DAY_W-1:0]    req_start_day;
   logic [dad_pkg::OFF_W-1:0]    req_days_away;
   logic                         rsp_valid;
   logic [dad_pkg::YEAR_W-1:0]   rsp_result_year;
   logic [dad_pkg::MONTH_W-1:0]  rsp_result_month;
   logic [dad_pkg::DAY_W-1:0]    rsp_result_day;
   logic [dad_pkg::STATUS_W-1:0] rsp_status;

   date_scoreboard sb;
   bit             idle_enable;
   int unsigned    quiet_cycles;

   date_add_days_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_days_away    (req_days_away),
      .rsp_valid        (rsp_valid),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // monitor: results first, since the next transaction may be taken on the strobe edge
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(date_rsp_type'{rsp_result_year, rsp_result_month,
                                        rsp_result_day, rsp_status});
      if (!reset && start && !busy)
         sb.note_input(req_start_year, req_start_month, req_start_day, req_days_away);
      if (reset || rsp_valid || (start && !busy))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_date(input logic [dad_pkg::YEAR_W-1:0] yr,
                            input logic [dad_pkg::MONTH_W-1:0] mo,
                            input logic [dad_pkg::DAY_W-1:0] dy,
                            input logic [dad_pkg::OFF_W-1:0] off);
      while (idle_enable && $urandom_range(0, 99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_start_year  <= yr;
      req_start_month <= mo;
      req_start_day   <= dy;
      req_days_away   <= off;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random_date();
      int unsigned                 kind, span;
      logic [dad_pkg::YEAR_W-1:0]  yr;
      logic [dad_pkg::MONTH_W-1:0] mo;
      logic [dad_pkg::DAY_W-1:0]   dy;
      logic [dad_pkg::OFF_W-1:0]   off;
      kind = $urandom_range(0, 99);
      span = $urandom_range(0, 99);
      if (span < 60)
         off = 16'($urandom_range(0, 62));
      else if (span < 85)
         off = 16'($urandom_range(0, 3000));
      else
         off = 16'($urandom_range(0, 65535));
      if (kind < 20) begin
         yr = 14'($urandom_range(0, 16383));
         mo = 4'($urandom_range(0, 15));
         dy = 5'($urandom_range(0, 31));
      end else begin
         if (kind < 26)
            yr = 14'($urandom_range(16200, dad_pkg::YEAR_TOP));
         else if (kind < 36)
            yr = 14'($urandom_range(0, 16383));
         else
            yr = 14'($urandom_range(dad_pkg::YEAR_MIN, 9999));
         mo = 4'($urandom_range(1, dad_pkg::MONTHS));
         dy = 5'($urandom_range(1, date_scoreboard::month_length(32'(mo), 32'(yr))));
         // give top-of-range years long offsets, which saturate many of them
         if (kind < 26)
            off = 16'($urandom_range(30000, 65535));
      end
      send_date(yr, mo, dy, off);
   endtask

   initial begin
      sb              = new();
      idle_enable     = 1'b1;
      quiet_cycles    = 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_start_year  <= '0;
      req_start_month <= '0;
      req_start_day   <= '0;
      req_days_away   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_date(2000, 1, 1, 0);
      send_date(2000, 0, 15, 10);
      send_date(2000, 13, 15, 10);
      send_date(16383, 15, 31, 65535);
      send_date(2000, 1, 0, 5);
      send_date(2000, 4, 31, 5);
      send_date(2023, 2, 29, 1);
      send_date(2024, 2, 29, 0);
      send_date(1900, 2, 29, 3);
      send_date(2000, 2, 29, 365);
      send_date(1582, 12, 31, 1);
      send_date(0, 6, 10, 1);
      send_date(0, 6, 31, 1);
      send_date(1583, 1, 1, 0);
      send_date(1583, 1, 1, 65535);
      send_date(2023, 12, 31, 1);
      send_date(2023, 2, 28, 1);
      send_date(8192, 1, 31, 32768);
      send_date(9999, 12, 31, 65535);
      send_date(16383, 12, 1, 30);
      send_date(16383, 12, 31, 1);
      send_date(16383, 1, 1, 65535);
      send_date(16300, 6, 15, 65535);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // long run with the sender never pausing
         idle_enable = !(i >= 90 && i < 150);
         send_random_date();
      end
      start <= 1'b0;

      @(posedge clock);
      while (sb.expected_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
